@@ rtl/core/playfair_digraph_cipher_defines.svh @@
// Assertion macros for the Playfair digraph cipher RTL.
// Clocked on clock, disabled during reset; used by the top level.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define PFC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PFC_ASSERT_NOW(lbl, ante, cons, msg)
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/pfc_pkg.sv @@
// Shared types, constants and key square helpers for the Playfair cipher.
// No dependencies.
package pfc_pkg;

   localparam int LETTER_W  = 5;
   localparam int SQ_N      = 5;
   localparam int ROW_W     = SQ_N * LETTER_W;
   localparam int SQUARE_W  = SQ_N * ROW_W;
   localparam int COORD_W   = 3;
   localparam int CSR_IDX_W = 3;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [COORD_W-1:0]  coord_type;
   typedef logic [ROW_W-1:0]    row_type;
   typedef logic [SQUARE_W-1:0] square_type;   // cell r*5+c at bits 5*(r*5+c)
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam letter_type PAD_LETTER = 5'd23;  // X
   localparam letter_type LETTER_I   = 5'd8;
   localparam letter_type LETTER_J   = 5'd9;

   localparam csr_idx_type CSR_MODE = 3'd0;
   localparam csr_idx_type CSR_ROW0 = 3'd1;
   localparam csr_idx_type CSR_ROW4 = 3'd5;

   localparam row_type ROW0_RESET = 25'd4294688;
   localparam row_type ROW1_RESET = 25'd10788037;
   localparam row_type ROW2_RESET = 25'd16201099;
   localparam row_type ROW3_RESET = 25'd21613104;
   localparam row_type ROW4_RESET = 25'd27025109;

   typedef struct packed {
      coord_type row;
      coord_type col;
   } pos_type;

   // One digraph waiting for substitution; twice: emit it two times
   typedef struct packed {
      letter_type first;
      letter_type second;
      logic       twice;
   } pair_type;

   typedef struct packed {
      letter_type first;
      letter_type second;
   } subst_type;

   function automatic logic is_ij(letter_type v);
      return (v == LETTER_I) || (v == LETTER_J);
   endfunction

   function automatic letter_type cell_at(square_type sq, coord_type r, coord_type c);
      logic [LETTER_W-1:0] idx;
      idx = LETTER_W'(r) * LETTER_W'(SQ_N) + LETTER_W'(c);
      return sq[LETTER_W*idx +: LETTER_W];
   endfunction

   // First matching cell in row-major order wins; no match gives 0,0
   function automatic pos_type locate(square_type sq, letter_type letter);
      pos_type    p;
      letter_type v;
      p = '0;
      for (int r = SQ_N - 1; r >= 0; r--) begin
         for (int c = SQ_N - 1; c >= 0; c--) begin
            v = sq[LETTER_W*(r*SQ_N + c) +: LETTER_W];
            if ((v == letter) || (is_ij(letter) && is_ij(v))) begin
               p.row = COORD_W'(r);
               p.col = COORD_W'(c);
            end
         end
      end
      return p;
   endfunction

   // +1 mod 5 encrypting, -1 mod 5 decrypting
   function automatic coord_type step_mod(coord_type x, logic dec);
      coord_type y;
      if (dec) begin
         y = (x == '0) ? COORD_W'(SQ_N - 1) : x - 1'b1;
      end else begin
         y = (x == COORD_W'(SQ_N - 1)) ? '0 : x + 1'b1;
      end
      return y;
   endfunction

endpackage

@@ rtl/core/pfc_if.sv @@
// Valid/ready channel interfaces for requests, results and register writes.
// Depends on pfc_pkg.
interface pfc_req_if;
   logic                 valid;
   logic                 ready;
   pfc_pkg::letter_type  letter_in;
   logic                 message_end;
   modport source (output valid, letter_in, message_end, input ready);
   modport sink   (input valid, letter_in, message_end, output ready);
endinterface

interface pfc_rsp_if;
   logic                 valid;
   logic                 ready;
   pfc_pkg::letter_type  letter_out;
   logic                 run_last;
   modport source (output valid, letter_out, run_last, input ready);
   modport sink   (input valid, letter_out, run_last, output ready);
endinterface

interface pfc_csr_if;
   logic                  valid;
   logic                  ready;
   pfc_pkg::csr_idx_type  index;
   pfc_pkg::row_type      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/pfc_pair.sv @@
// Digraph former: pending-letter state and the pair register.
// Depends on pfc_pkg and pfc_req_if.
module pfc_pair (
   input  logic              clock,
   input  logic              reset,
   pfc_req_if.sink           req_ch,
   input  logic              decrypt_mode,
   input  logic              take,
   output pfc_pkg::pair_type pair,
   output logic              pair_valid
);
   import pfc_pkg::*;

   letter_type held_letter_ff, held_letter_in;
   logic       held_valid_ff, held_valid_in;
   pair_type   pair_ff, pair_in;
   logic       pair_valid_ff, pair_valid_in;
   logic       accept;

   assign req_ch.ready = !pair_valid_ff || take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      held_letter_in = held_letter_ff;
      held_valid_in  = held_valid_ff;
      pair_in        = pair_ff;
      pair_valid_in  = pair_valid_ff && !take;
      if (accept) begin
         if (!held_valid_ff) begin
            if (req_ch.message_end) begin
               pair_in       = '{first: req_ch.letter_in, second: PAD_LETTER, twice: 1'b0};
               pair_valid_in = 1'b1;
            end else begin
               held_letter_in = req_ch.letter_in;
               held_valid_in  = 1'b1;
            end
         end else if (!decrypt_mode && (req_ch.letter_in == held_letter_ff)) begin
            // doubled letter: held+X, and a final one is padded again
            pair_in       = '{first: held_letter_ff, second: PAD_LETTER,
                              twice: req_ch.message_end};
            pair_valid_in = 1'b1;
            held_valid_in = !req_ch.message_end;
         end else begin
            pair_in       = '{first: held_letter_ff, second: req_ch.letter_in, twice: 1'b0};
            pair_valid_in = 1'b1;
            held_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff  <= 1'b0;
         held_letter_ff <= '0;
         pair_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff  <= held_valid_in;
         held_letter_ff <= held_letter_in;
         pair_valid_ff  <= pair_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   assign pair       = pair_ff;
   assign pair_valid = pair_valid_ff;

endmodule

@@ rtl/core/pfc_subst.sv @@
// Key square substitution of one digraph: row, column or rectangle rule.
// Depends on pfc_pkg.
module pfc_subst (
   input  pfc_pkg::square_type square,
   input  logic                decrypt_mode,
   input  pfc_pkg::pair_type   pair,
   output pfc_pkg::subst_type  result
);
   import pfc_pkg::*;

   pos_type p1, p2;

   always_comb begin
      p1 = locate(square, pair.first);
      p2 = locate(square, pair.second);
      if (p1.row == p2.row) begin
         // also covers both letters in one cell
         result.first  = cell_at(square, p1.row, step_mod(p1.col, decrypt_mode));
         result.second = cell_at(square, p2.row, step_mod(p2.col, decrypt_mode));
      end else if (p1.col == p2.col) begin
         result.first  = cell_at(square, step_mod(p1.row, decrypt_mode), p1.col);
         result.second = cell_at(square, step_mod(p2.row, decrypt_mode), p2.col);
      end else begin
         result.first  = cell_at(square, p1.row, p2.col);
         result.second = cell_at(square, p2.row, p1.col);
      end
   end

endmodule

@@ rtl/core/playfair_digraph_cipher.sv @@
// Playfair digraph cipher, top level: register file, pairing, substitution, result buffer.
// A completing letter passes the pair register, then the result buffer, before it shows.
// Throughput: one result letter per cycle while the result channel is ready; a pair gives
//   two, a final doubled letter four, a held one none: one plain letter per cycle unless padded.
// Reset (synchronous): nothing pending, encrypt mode, square A-E/F-K/L-P/Q-U/V-Z.
// Depends on pfc_pkg, pfc_if, pfc_pair, pfc_subst and the defines header.
`include "playfair_digraph_cipher_defines.svh"

module playfair_digraph_cipher (
   input  logic     clock,
   input  logic     reset,
   pfc_req_if.sink  req_ch,
   pfc_rsp_if.source rsp_ch,
   pfc_csr_if.sink  csr_ch
);
   import pfc_pkg::*;

   // ---- configuration registers ----
   logic        decrypt_mode_ff;
   square_type  square_ff;
   csr_idx_type row_sel;

   assign csr_ch.ready = 1'b1;
   assign row_sel      = csr_ch.index - CSR_ROW0;

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_mode_ff <= 1'b0;
         square_ff       <= {ROW4_RESET, ROW3_RESET, ROW2_RESET, ROW1_RESET, ROW0_RESET};
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index) inside
            CSR_MODE:             decrypt_mode_ff <= csr_ch.data[0];
            [CSR_ROW0:CSR_ROW4]:  square_ff[ROW_W*row_sel +: ROW_W] <= csr_ch.data;
            default: ;            // unmapped index: write dropped
         endcase
      end
   end

   // ---- pairing stage ----
   pair_type  pair;
   logic      pair_valid;
   logic      take;

   pfc_pair u_pair (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .decrypt_mode (decrypt_mode_ff),
      .take         (take),
      .pair         (pair),
      .pair_valid   (pair_valid)
   );

   // ---- substitution, straight from the pair register ----
   subst_type sub;

   pfc_subst u_subst (
      .square       (square_ff),
      .decrypt_mode (decrypt_mode_ff),
      .pair         (pair),
      .result       (sub)
   );

   // ---- result buffer: holds one substituted pair, sent out one letter a cycle while ready ----
   // idx counts the letters sent: 0,1 for a single pair, 0..3 when repeated.
   subst_type  out_ff, out_in;
   logic       twice_ff, twice_in;
   logic [1:0] idx_ff, idx_in;
   logic       buf_valid_ff, buf_valid_in;
   logic       last_beat;
   logic       rsp_fire;

   assign last_beat = (idx_ff[1] == twice_ff) && idx_ff[0];
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   // buffer refills as its last letter leaves, so pairs go out without a gap
   assign take      = pair_valid && (!buf_valid_ff || (rsp_fire && last_beat));

   always_comb begin
      out_in       = out_ff;
      twice_in     = twice_ff;
      idx_in       = idx_ff;
      buf_valid_in = buf_valid_ff;
      if (rsp_fire) begin
         idx_in = idx_ff + 2'd1;
         if (last_beat) begin
            buf_valid_in = 1'b0;
         end
      end
      if (take) begin
         out_in       = sub;
         twice_in     = pair.twice;
         idx_in       = '0;
         buf_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= '0;
         twice_ff     <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         idx_ff       <= idx_in;
         twice_ff     <= twice_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_ch.valid      = buf_valid_ff;
   assign rsp_ch.letter_out = idx_ff[0] ? out_ff.second : out_ff.first;
   assign rsp_ch.run_last   = last_beat;

   // ---- checks ----
   `PFC_ASSERT_NOW(a_last_on_second, rsp_ch.valid && rsp_ch.run_last, idx_ff[0], "run_last on first letter of a pair")
   `PFC_ASSERT_NOW(a_idx_range, buf_valid_ff && !twice_ff, !idx_ff[1], "letter count past a single pair")
   `PFC_ASSERT_NEXT(a_drain, rsp_fire && last_beat && !pair_valid, !buf_valid_ff, "buffer not freed after last letter")
   `PFC_ASSERT_NEXT(a_refill, take, buf_valid_ff && (idx_ff == 2'd0), "pair taken but buffer not loaded")

endmodule

@@ bench/playfair_digraph_cipher_tb.sv @@
// Self-checking bench for playfair_digraph_cipher: directed and random letter streams,
// both modes, many key squares, checked letter by letter against an in-bench predictor.
// Depends on pfc_pkg, pfc_if and the playfair_digraph_cipher RTL.
`timescale 1ns / 1ps

module playfair_digraph_cipher_tb;
   import pfc_pkg::*;

   // Register indexes past the end of the register list; writes there must be dropped
   localparam csr_idx_type CSR_SPARE_LO = CSR_ROW4 + 3'd1;
   localparam csr_idx_type CSR_SPARE_HI = CSR_ROW4 + 3'd2;

   // One letter on the result channel
   typedef struct packed {
      letter_type letter;
      logic       last;
   } cipher_letter_type;

   // One pending register write
   typedef struct packed {
      csr_idx_type idx;
      row_type     data;
   } csr_write_type;

   // Predicts the cipher output: own copy of mode, square and the pending letter
   class digraph_scoreboard;
      logic              decrypting;
      row_type           key_rows[SQ_N];
      letter_type        held;
      logic              holding;
      cipher_letter_type expected_letters[$];
      int                mismatches;
      int                checked;

      function new();
         decrypting  = 1'b0;
         key_rows[0] = ROW0_RESET;
         key_rows[1] = ROW1_RESET;
         key_rows[2] = ROW2_RESET;
         key_rows[3] = ROW3_RESET;
         key_rows[4] = ROW4_RESET;
         held        = '0;
         holding     = 1'b0;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function void write_reg(csr_idx_type idx, row_type value);
         if (idx == CSR_MODE) begin
            decrypting = value[0];
         end else if (idx <= CSR_ROW4) begin
            key_rows[idx - CSR_ROW0] = value;
         end
      endfunction

      function letter_type cell_code(int r, int c);
         return key_rows[r % SQ_N][LETTER_W*(c % SQ_N) +: LETTER_W];
      endfunction

      // First cell in row-major order; I and J match each other; none found: 0,0
      function void find_cell(letter_type l, output int r, output int c);
         int         i;
         bit         found;
         letter_type v;
         found = 1'b0;
         r = 0;
         c = 0;
         for (i = 0; i < SQ_N*SQ_N && !found; i++) begin
            v = cell_code(i / SQ_N, i % SQ_N);
            if (v == l || ((l == LETTER_I || l == LETTER_J) &&
                           (v == LETTER_I || v == LETTER_J))) begin
               found = 1'b1;
               r = i / SQ_N;
               c = i % SQ_N;
            end
         end
      endfunction

      // Substitute one digraph; closes marks the second letter as the item's last
      function void add_digraph(letter_type a, letter_type b, logic closes);
         int                ra, ca, rb, cb, step;
         cipher_letter_type x, y;
         step = decrypting ? SQ_N - 1 : 1;
         find_cell(a, ra, ca);
         find_cell(b, rb, cb);
         if (ra == rb) begin
            x.letter = cell_code(ra, ca + step);
            y.letter = cell_code(rb, cb + step);
         end else if (ca == cb) begin
            x.letter = cell_code(ra + step, ca);
            y.letter = cell_code(rb + step, cb);
         end else begin
            x.letter = cell_code(ra, cb);
            y.letter = cell_code(rb, ca);
         end
         x.last = 1'b0;
         y.last = closes;
         expected_letters = {expected_letters, x, y};
      endfunction

      function void note_letter(letter_type l, logic fin);
         if (!holding) begin
            if (fin) begin
               add_digraph(l, PAD_LETTER, 1'b1);
            end else begin
               held    = l;
               holding = 1'b1;
            end
         end else if (!decrypting && l == held) begin
            // doubled letter: pad the held one, the new one waits or, if final, is padded too
            add_digraph(held, PAD_LETTER, !fin);
            if (fin) begin
               add_digraph(l, PAD_LETTER, 1'b1);
               holding = 1'b0;
               held    = '0;
            end
         end else begin
            add_digraph(held, l, 1'b1);
            holding = 1'b0;
            held    = '0;
         end
      endfunction

      function void log_mismatch(string text);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%t mismatch: %s", $realtime, text);
         end
      endfunction

      function void check_result(letter_type l, logic last);
         cipher_letter_type want;
         checked++;
         if (expected_letters.size() == 0) begin
            log_mismatch($sformatf("unexpected letter %0d last %0b", l, last));
         end else begin
            want = expected_letters.pop_front();
            if (want.letter !== l) begin
               log_mismatch($sformatf("letter_out expected %0d got %0d", want.letter, l));
            end
            if (want.last !== last) begin
               log_mismatch($sformatf("run_last expected %0b got %0b (letter %0d)",
                                      want.last, last, l));
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   pfc_req_if req_ch ();
   pfc_rsp_if rsp_ch ();
   pfc_csr_if csr_ch ();

   playfair_digraph_cipher dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   digraph_scoreboard sb;
   csr_write_type     csr_writes[$];
   row_type           key_plan[SQ_N];
   bit                steady;           // no idling on either side while set
   int                letters_sent;
   int                results_taken  = 0;
   int                settings_used;
   int                hold_left      = 0;
   bit                long_hold_done = 1'b0;

   always #5 clock = ~clock;

   // Safety net: a hung handshake ends the run as a failure
   initial begin
      #2_000_000;
      $display("playfair_digraph_cipher_tb failed");
      $finish;
   end

   // Result side: check every accepted letter, drive ready.
   // Once, after 80 results, ready is held low so the block backs up.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result(rsp_ch.letter_out, rsp_ch.run_last);
         results_taken++;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (!long_hold_done && results_taken >= 80) begin
         long_hold_done = 1'b1;
         hold_left      = 79;
         rsp_ch.ready   <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 15);
      end
   end

   // Queue one register write for the next flush
   function void queue_write(csr_idx_type idx, row_type data);
      csr_write_type w;
      w.idx      = idx;
      w.data     = data;
      csr_writes = {csr_writes, w};
   endfunction

   // Offer one letter, idling at random first; returns at the accepting edge with
   // valid still high, so the caller either offers the next item or lowers valid.
   task automatic send_letter(input letter_type l, input logic fin);
      while (!steady && $urandom_range(0, 99) < 15) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.letter_in   <= l;
      req_ch.message_end <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_letter(l, fin);
      letters_sent++;
   endtask

   // Stop offering, let every expected letter come out, then allow for the pair
   // register and result buffer in case a held letter is still in flight.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_letters.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Push out the queued register writes back to back
   task automatic flush_csr_writes();
      csr_write_type w;
      while (csr_writes.size() != 0) begin
         w = csr_writes.pop_front();
         csr_ch.valid <= 1'b1;
         csr_ch.index <= w.idx;
         csr_ch.data  <= w.data;
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         sb.write_reg(w.idx, w.data);
      end
      csr_ch.valid <= 1'b0;
   endtask

   // Drain, then load the mode and all five rows from key_plan
   task automatic apply_settings(input logic decrypt);
      int i;
      wait_drained();
      queue_write(CSR_MODE, row_type'(decrypt));
      for (i = 0; i < SQ_N; i++) begin
         queue_write(CSR_ROW0 + csr_idx_type'(i), key_plan[i]);
      end
      flush_csr_writes();
      settings_used++;
   endtask

   // A proper key: 25 distinct letters, either I or J left out, shuffled
   task automatic plan_shuffled_square();
      letter_type pool[SQ_N*SQ_N];
      letter_type t;
      letter_type skip;
      int         k, j, code;
      skip = $urandom_range(0, 1) ? LETTER_J : LETTER_I;
      k = 0;
      for (code = 0; code <= 25; code++) begin
         if (letter_type'(code) != skip) begin
            pool[k] = letter_type'(code);
            k++;
         end
      end
      for (k = SQ_N*SQ_N - 1; k > 0; k--) begin
         j       = $urandom_range(0, k);
         t       = pool[k];
         pool[k] = pool[j];
         pool[j] = t;
      end
      for (k = 0; k < SQ_N*SQ_N; k++) begin
         key_plan[k / SQ_N][LETTER_W*(k % SQ_N) +: LETTER_W] = pool[k];
      end
   endtask

   // Random letters; a quarter repeat the previous one so doubled letters are common
   task automatic run_random(input int count, input bit pause_midway);
      letter_type l, prev;
      logic       fin;
      int         n;
      prev = letter_type'($urandom_range(0, 25));
      for (n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2) begin
            wait_drained();
         end
         l   = ($urandom_range(0, 3) == 0) ? prev : letter_type'($urandom_range(0, 25));
         fin = ($urandom_range(0, 99) < 15);
         send_letter(l, fin);
         prev = l;
      end
   endtask

   initial begin
      int i;
      sb                 = new();
      steady             = 1'b0;
      letters_sent       = 0;
      settings_used      = 1;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.letter_in   <= '0;
      req_ch.message_end <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= CSR_MODE;
      csr_ch.data        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ---- directed, encrypt, reset square ----
      send_letter(5'd0, 1'b0);   // A B: same row
      send_letter(5'd1, 1'b0);
      send_letter(5'd0, 1'b0);   // A F: same column
      send_letter(5'd5, 1'b0);
      send_letter(5'd0, 1'b0);   // A Z: rectangle, message ends on a full pair
      send_letter(5'd25, 1'b1);
      send_letter(5'd4, 1'b0);   // E E E(end): each E padded with X, six letters out
      send_letter(5'd4, 1'b0);
      send_letter(5'd4, 1'b1);
      send_letter(5'd8, 1'b0);   // I J: distinct codes, one shared cell
      send_letter(5'd9, 1'b0);
      send_letter(5'd25, 1'b1);  // lone final Z, padded with X
      send_letter(5'd31, 1'b0);  // code off the square sits at 0,0
      send_letter(5'd12, 1'b1);
      send_letter(5'd23, 1'b0);  // X X(end): pad equals the letter
      send_letter(5'd23, 1'b1);
      send_letter(5'd3, 1'b0);   // D left pending across the mode change

      // Switch to decrypt with D still held; spare indexes must be ignored
      wait_drained();
      queue_write(CSR_SPARE_LO, row_type'($urandom));
      queue_write(CSR_MODE, row_type'(1));
      queue_write(CSR_SPARE_HI, row_type'($urandom));
      flush_csr_writes();
      settings_used++;

      // ---- directed, decrypt ----
      send_letter(5'd3, 1'b0);   // D D: paired as given, no padding
      send_letter(5'd0, 1'b0);   // A B: column wraps 0 -> 4
      send_letter(5'd1, 1'b0);
      send_letter(5'd0, 1'b0);   // A V: row wraps 0 -> 4
      send_letter(5'd20, 1'b0);
      send_letter(5'd7, 1'b1);   // lone final H padded even when decrypting

      // ---- random phases over a spread of settings ----
      plan_shuffled_square();
      apply_settings(1'b0);
      run_random(30, 1'b1);      // sender pause part-way through

      apply_settings(1'b1);      // same key, decrypt, no idling anywhere
      steady = 1'b1;
      run_random(30, 1'b0);
      steady = 1'b0;

      for (i = 0; i < SQ_N; i++) key_plan[i] = '1;   // every cell 31: nothing found
      apply_settings(1'b0);
      run_random(15, 1'b0);

      for (i = 0; i < SQ_N; i++) key_plan[i] = '0;   // every cell A: first cell wins
      apply_settings(1'b1);
      run_random(15, 1'b0);

      for (i = 0; i < SQ_N; i++) key_plan[i] = row_type'($urandom);  // junk rows
      apply_settings(1'b0);
      run_random(20, 1'b0);

      plan_shuffled_square();
      apply_settings(1'b1);
      run_random(15, 1'b0);

      key_plan[0] = ROW0_RESET;
      key_plan[1] = ROW1_RESET;
      key_plan[2] = ROW2_RESET;
      key_plan[3] = ROW3_RESET;
      key_plan[4] = ROW4_RESET;
      apply_settings(1'b0);
      run_random(15, 1'b0);

      wait_drained();

      $display("Sent %0d letters, checked %0d cipher letters over %0d register settings.",
               letters_sent, sb.checked, settings_used);
      $display("Both modes; reset, shuffled, all-zero, all-ones and junk key squares.");
      if (sb.expected_letters.size() != 0) begin
         $display("%0d expected letters never arrived", sb.expected_letters.size());
      end
      if (sb.mismatches == 0 && sb.expected_letters.size() == 0) begin
         $display("playfair_digraph_cipher_tb passed");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("playfair_digraph_cipher_tb failed");
      end
      $finish;
   end

endmodule

@@ playfair_digraph_cipher.f @@
+incdir+rtl/core
rtl/core/pfc_pkg.sv
rtl/core/pfc_if.sv
rtl/core/pfc_pair.sv
rtl/core/pfc_subst.sv
rtl/core/playfair_digraph_cipher.sv
bench/playfair_digraph_cipher_tb.sv
